FILE: sv/mpt_pkg.sv
`timescale 1ns / 1ps
// Package for the pipe thermostat: codes, register indexes, shared types
// and the CRC-16 byte update. No dependencies.
package mpt_pkg;

   localparam int FRAME_DEPTH = 8;
   localparam int CHANNELS    = 3;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [15:0] FAULT_RAW = 16'h7FFF;

   localparam logic [3:0] CRC_END     = 4'd9;
   localparam logic [3:0] FRAME_FIRST = 4'd3;
   localparam logic [3:0] FRAME_LAST  = 4'd10;
   localparam logic [3:0] MIN_FRAME   = 4'd11;
   localparam logic [3:0] COUNT_MAX   = 4'd15;
   localparam logic [1:0] MISS_MAX    = 2'd3;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_POLL = 1'b1;

   localparam logic [1:0] STATUS_VALID = 2'd0;
   localparam logic [1:0] STATUS_BAD   = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [2:0] REG_HEAT_ON_BELOW    = 3'd0;
   localparam logic [2:0] REG_HEAT_OFF_ABOVE   = 3'd1;
   localparam logic [2:0] REG_COLD_ALARM_BELOW = 3'd2;
   localparam logic [2:0] REG_HOT_ALARM_ABOVE  = 3'd3;
   localparam logic [2:0] REG_MISS_LIMIT       = 3'd4;

   typedef struct packed {
      logic signed [15:0] heat_on_below;
      logic signed [15:0] heat_off_above;
      logic signed [15:0] cold_alarm_below;
      logic signed [15:0] hot_alarm_above;
      logic [1:0]         miss_limit;
   } cfg_type;

   typedef struct packed {
      logic [CHANNELS-1:0][15:0] temps;
      logic [1:0]                miss_count;
      logic                      heater;
      logic                      beeper;
   } poll_state_type;

   typedef struct packed {
      logic [CHANNELS-1:0][15:0] temps;
      logic                      heater_on;
      logic                      beeper_on;
      logic [CHANNELS-1:0]       channel_faults;
      logic                      box_fault;
      logic                      cold_alarm;
      logic                      hot_alarm;
      logic                      link_lost;
      logic [1:0]                poll_status;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: sv/mpt_req_if.sv
`timescale 1ns / 1ps
// Input channel: reply bytes and poll-end markers with valid/ready.
// No dependencies.
interface mpt_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;
   logic       box_sensor_ok;

   modport source (output valid, action, rx_byte, box_sensor_ok, input ready);
   modport sink   (input valid, action, rx_byte, box_sensor_ok, output ready);
endinterface

FILE: sv/mpt_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one poll report per transfer with valid/ready.
// No dependencies.
interface mpt_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] temp_one;
   logic signed [15:0] temp_two;
   logic signed [15:0] temp_three;
   logic              heater_on;
   logic              beeper_on;
   logic [2:0]        channel_faults;
   logic              box_fault;
   logic              cold_alarm;
   logic              hot_alarm;
   logic              link_lost;
   logic [1:0]        poll_status;

   modport source (output valid, temp_one, temp_two, temp_three, heater_on, beeper_on,
                   channel_faults, box_fault, cold_alarm, hot_alarm, link_lost,
                   poll_status, input ready);
   modport sink   (input valid, temp_one, temp_two, temp_three, heater_on, beeper_on,
                   channel_faults, box_fault, cold_alarm, hot_alarm, link_lost,
                   poll_status, output ready);
endinterface

FILE: sv/mpt_poll_eval.sv
`timescale 1ns / 1ps
// Poll-end evaluation: frame check, channel capture, heater and alarm logic.
// Depends on mpt_pkg.
module mpt_poll_eval (
   input  mpt_pkg::cfg_type        cfg,
   input  logic [3:0]              byte_count,
   input  logic [15:0]             crc_accum,
   input  logic [7:0]              frame_bytes [mpt_pkg::FRAME_DEPTH],
   input  logic                    box_sensor_ok,
   input  mpt_pkg::poll_state_type state_cur,
   output mpt_pkg::poll_state_type state_nxt,
   output mpt_pkg::result_type     result
);
   import mpt_pkg::*;

   logic [CHANNELS-1:0][15:0] raw;
   logic [CHANNELS-1:0]       fault_raw;
   logic [CHANNELS-1:0]       below_on, above_off, below_cold, above_hot;
   logic [1:0]                status;
   logic [1:0]                miss_inc;
   logic                      box_fault;
   logic                      cold, hot, lost;
   logic [CHANNELS-1:0]       faults;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         raw[i]        = {frame_bytes[2*i], frame_bytes[2*i+1]};
         fault_raw[i]  = (raw[i] == FAULT_RAW);
         below_on[i]   = $signed(raw[i]) < cfg.heat_on_below;
         above_off[i]  = $signed(raw[i]) > cfg.heat_off_above;
         below_cold[i] = $signed(raw[i]) < cfg.cold_alarm_below;
         above_hot[i]  = $signed(raw[i]) > cfg.hot_alarm_above;
      end
   end

   always_comb begin
      box_fault = ~box_sensor_ok;
      cold      = 1'b0;
      hot       = 1'b0;
      lost      = 1'b0;
      faults    = '0;
      state_nxt = state_cur;
      miss_inc  = (state_cur.miss_count < MISS_MAX) ? state_cur.miss_count + 2'd1
                                                     : state_cur.miss_count;

      priority if (byte_count == 4'd0) begin
         status = STATUS_EMPTY;
      end else if (byte_count < MIN_FRAME || frame_bytes[6] != crc_accum[7:0]
                   || frame_bytes[7] != crc_accum[15:8]) begin
         status = STATUS_BAD;
      end else begin
         status = STATUS_VALID;
      end

      if (status == STATUS_VALID) begin
         state_nxt.miss_count = 2'd0;
         state_nxt.temps      = raw;
         faults               = fault_raw;
         if (&fault_raw) begin
            state_nxt.heater = 1'b1;
            state_nxt.beeper = 1'b1;
         end else begin
            if (|below_on) begin
               state_nxt.heater = 1'b1;
            end else if (&above_off) begin
               state_nxt.heater = 1'b0;
            end
            cold = &below_cold;
            hot  = &above_hot;
            if (cold) begin
               state_nxt.heater = 1'b1;
               state_nxt.beeper = 1'b1;
            end
            if (hot) begin
               state_nxt.heater = 1'b0;
               state_nxt.beeper = 1'b1;
            end
         end
      end else begin
         state_nxt.miss_count = miss_inc;
         if (miss_inc >= cfg.miss_limit) begin
            state_nxt.miss_count = cfg.miss_limit;
            lost                 = 1'b1;
            state_nxt.temps      = {CHANNELS{FAULT_RAW}};
            faults               = '1;
            state_nxt.heater     = 1'b1;
            state_nxt.beeper     = 1'b1;
         end
      end

      if (!box_fault && faults == '0 && !cold && !hot && !lost) begin
         state_nxt.beeper = 1'b0;
      end

      result.temps          = state_nxt.temps;
      result.heater_on      = state_nxt.heater;
      result.beeper_on      = state_nxt.beeper;
      result.channel_faults = faults;
      result.box_fault      = box_fault;
      result.cold_alarm     = cold;
      result.hot_alarm      = hot;
      result.link_lost      = lost;
      result.poll_status    = status;
   end

endmodule

FILE: sv/modbus_pipe_thermostat_unit.sv
`timescale 1ns / 1ps
// Pipe thermostat fed by a three-channel Modbus RTU reply; depends on mpt_pkg,
// mpt_req_if, mpt_rsp_if and mpt_poll_eval.
// A poll-end transfer passes the input register and then the output register.
// Throughput: one transfer per cycle, but a poll end stalls while a report waits;
// the CRC update and poll evaluation are combinational on the input register.
// Reset (synchronous): thresholds to defaults, CRC to 0xFFFF, temperatures 0x7FFF.
module modbus_pipe_thermostat_unit (
   input  logic        clock,
   input  logic        reset,
   mpt_req_if.sink     req_ch,
   mpt_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import mpt_pkg::*;

   cfg_type        cfg_ff;
   logic           in_valid_ff;
   logic           in_action_ff;
   logic [7:0]     in_byte_ff;
   logic           in_box_ok_ff;
   logic [3:0]     byte_count_ff;
   logic [15:0]    crc_ff;
   logic [7:0]     frame_ff [FRAME_DEPTH];
   poll_state_type state_ff;
   poll_state_type state_in;
   logic           out_valid_ff;
   result_type     out_ff;
   result_type     result_in;
   logic           advance;
   logic [2:0]     frame_idx;

   assign advance      = in_valid_ff && (in_action_ff == ACT_BYTE || !out_valid_ff
                                         || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign frame_idx    = 3'(byte_count_ff - FRAME_FIRST);

   mpt_poll_eval u_eval (
      .cfg           (cfg_ff),
      .byte_count    (byte_count_ff),
      .crc_accum     (crc_ff),
      .frame_bytes   (frame_ff),
      .box_sensor_ok (in_box_ok_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_in),
      .result        (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heat_on_below    <= 16'sd50;
         cfg_ff.heat_off_above   <= 16'sd100;
         cfg_ff.cold_alarm_below <= 16'sd0;
         cfg_ff.hot_alarm_above  <= 16'sd150;
         cfg_ff.miss_limit       <= 2'd3;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_HEAT_ON_BELOW:    cfg_ff.heat_on_below    <= csr_wdata;
            REG_HEAT_OFF_ABOVE:   cfg_ff.heat_off_above   <= csr_wdata;
            REG_COLD_ALARM_BELOW: cfg_ff.cold_alarm_below <= csr_wdata;
            REG_HOT_ALARM_ABOVE:  cfg_ff.hot_alarm_above  <= csr_wdata;
            REG_MISS_LIMIT:       cfg_ff.miss_limit       <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_action_ff <= req_ch.action;
         in_byte_ff   <= req_ch.rx_byte;
         in_box_ok_ff <= req_ch.box_sensor_ok;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_action_ff == ACT_BYTE && byte_count_ff >= FRAME_FIRST
          && byte_count_ff <= FRAME_LAST) begin
         frame_ff[frame_idx] <= in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= 4'd0;
         crc_ff         <= CRC_INIT;
         state_ff.temps <= {CHANNELS{FAULT_RAW}};
         state_ff.miss_count <= 2'd0;
         state_ff.heater <= 1'b0;
         state_ff.beeper <= 1'b0;
      end else if (advance) begin
         if (in_action_ff == ACT_BYTE) begin
            if (byte_count_ff < CRC_END) begin
               crc_ff <= crc_byte(crc_ff, in_byte_ff);
            end
            if (byte_count_ff < COUNT_MAX) begin
               byte_count_ff <= byte_count_ff + 4'd1;
            end
         end else begin
            byte_count_ff <= 4'd0;
            crc_ff        <= CRC_INIT;
            state_ff      <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_action_ff == ACT_POLL) begin
         out_ff <= result_in;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_action_ff == ACT_POLL) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.temp_one       = $signed(out_ff.temps[0]);
   assign rsp_ch.temp_two       = $signed(out_ff.temps[1]);
   assign rsp_ch.temp_three     = $signed(out_ff.temps[2]);
   assign rsp_ch.heater_on      = out_ff.heater_on;
   assign rsp_ch.beeper_on      = out_ff.beeper_on;
   assign rsp_ch.channel_faults = out_ff.channel_faults;
   assign rsp_ch.box_fault      = out_ff.box_fault;
   assign rsp_ch.cold_alarm     = out_ff.cold_alarm;
   assign rsp_ch.hot_alarm      = out_ff.hot_alarm;
   assign rsp_ch.link_lost      = out_ff.link_lost;
   assign rsp_ch.poll_status    = out_ff.poll_status;

endmodule
